// ===== rtl/core/mpvf_pkg.sv =====
// ----------------------------------------------------------------------------
// MS/TP present-value request framer package
// Request word type, frame constants and byte-wise CRC update functions.
// ----------------------------------------------------------------------------
package mpvf_pkg;

	typedef struct packed {
		logic        wr;
		logic        reject;
		logic [7:0]  dest;
		logic [7:0]  src;
		logic [23:0] dev;
		logic [9:0]  typ;
		logic [23:0] obj;
		logic [31:0] val;
	} req_t;

	localparam logic [7:0]  PREAMBLE_0  = 8'h55;
	localparam logic [7:0]  PREAMBLE_1  = 8'hFF;
	localparam logic [7:0]  FRAME_TYPE  = 8'h05;
	localparam logic [7:0]  PDU_TYPE    = 8'h01;
	localparam logic [7:0]  PDU_FLAGS   = 8'h04;
	localparam logic [7:0]  SVC_READ    = 8'h0C;
	localparam logic [7:0]  SVC_WRITE   = 8'h0F;
	localparam logic [7:0]  PROP_TAG    = 8'h55;
	localparam logic [7:0]  ADDR_NONE   = 8'h00;
	localparam logic [7:0]  ADDR_BCAST  = 8'hFF;
	localparam logic [7:0]  SRC_RESET   = 8'h01;
	localparam logic [7:0]  LEN_READ    = 8'd12;
	localparam logic [7:0]  LEN_WRITE   = 8'd16;

	localparam logic [7:0]  CRC8_POLY   = 8'h8C;
	localparam logic [7:0]  CRC8_INIT   = 8'hFF;
	localparam logic [15:0] CRC16_POLY  = 16'hA001;
	localparam logic [15:0] CRC16_INIT  = 16'hFFFF;

	localparam int          POS_W       = 5;
	localparam logic [4:0]  POS_HCRC_LO = 5'd2;
	localparam logic [4:0]  POS_HCRC_HI = 5'd6;
	localparam logic [4:0]  POS_PAYLOAD = 5'd8;
	localparam logic [4:0]  POS_DCRC_RD = 5'd20;
	localparam logic [4:0]  POS_DCRC_WR = 5'd24;
	localparam logic [4:0]  POS_LAST_RD = 5'd21;
	localparam logic [4:0]  POS_LAST_WR = 5'd25;

	function automatic logic [7:0] crc8_next(input logic [7:0] c, input logic [7:0] b);
		logic [7:0] r;
		r = c ^ b;
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/mpvf_front.sv =====
// ----------------------------------------------------------------------------
// MS/TP framer front end
// Holds the source address register, classifies each request and builds
// the request word pushed into the queue.
// ----------------------------------------------------------------------------
module mpvf_front
	import mpvf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               full,
	input  logic               opcode,
	input  logic [7:0]         dest_address,
	input  logic [23:0]        device_instance,
	input  logic [9:0]         object_type_code,
	input  logic [23:0]        object_instance,
	input  logic signed [31:0] value_hundredths,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_data,
	output logic               cfg_ready,
	output logic               push,
	output req_t               push_word
);

	logic [7:0] src_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= SRC_RESET;
		end else if (cfg_valid) begin
			src_addr_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign push      = start && !full;

	always_comb begin
		push_word.wr     = opcode;
		push_word.reject = (dest_address == ADDR_NONE) || (dest_address == ADDR_BCAST);
		push_word.dest   = dest_address;
		push_word.src    = src_addr_q;
		push_word.dev    = device_instance;
		push_word.typ    = object_type_code;
		push_word.obj    = object_instance;
		push_word.val    = $unsigned(value_hundredths);
	end

endmodule

// ===== rtl/core/mpvf_queue.sv =====
// ----------------------------------------------------------------------------
// MS/TP framer request queue
// Two-entry queue of request words between front end and serializer.
// ----------------------------------------------------------------------------
module mpvf_queue
	import mpvf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_word,
	input  logic pop,
	output req_t pop_word,
	output logic nonempty,
	output logic full
);

	req_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign pop_word = mem_q[rd_ptr_q];
	assign nonempty = (count_q != 2'd0);
	assign full     = count_q[1];

endmodule

// ===== rtl/core/mpvf_back.sv =====
// ----------------------------------------------------------------------------
// MS/TP framer back end
// Serializes one request word into frame bytes, one per cycle, with
// running header CRC-8 and data CRC-16.
// ----------------------------------------------------------------------------
module mpvf_back
	import mpvf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       nonempty,
	input  req_t       pop_word,
	output logic       pop,
	output logic       strobe,
	output logic [7:0] frame_byte,
	output logic       last,
	output logic       rejected
);

	logic             active_q;
	logic [POS_W-1:0] pos_q;
	req_t             req_q;
	logic [7:0]       crc8_q;
	logic [15:0]      crc16_q;
	logic             strobe_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             rej_q;

	logic [7:0]       cur_byte;
	logic             cur_last;
	logic [7:0]       plen;
	logic [POS_W-1:0] dcrc_pos;

	assign plen     = req_q.wr ? LEN_WRITE : LEN_READ;
	assign dcrc_pos = req_q.wr ? POS_DCRC_WR : POS_DCRC_RD;
	assign cur_last = req_q.reject || (pos_q == (req_q.wr ? POS_LAST_WR : POS_LAST_RD));
	assign pop      = nonempty && (!active_q || cur_last);

	always_comb begin
		if (req_q.reject) begin
			cur_byte = 8'h00;
		end else begin
			unique case (pos_q)
				5'd0:    cur_byte = PREAMBLE_0;
				5'd1:    cur_byte = PREAMBLE_1;
				5'd2:    cur_byte = FRAME_TYPE;
				5'd3:    cur_byte = req_q.dest;
				5'd4:    cur_byte = req_q.src;
				5'd5:    cur_byte = 8'h00;
				5'd6:    cur_byte = plen;
				5'd7:    cur_byte = ~crc8_q;
				5'd8:    cur_byte = PDU_TYPE;
				5'd9:    cur_byte = PDU_FLAGS;
				5'd10:   cur_byte = req_q.wr ? SVC_WRITE : SVC_READ;
				5'd11:   cur_byte = req_q.dev[23:16];
				5'd12:   cur_byte = req_q.dev[15:8];
				5'd13:   cur_byte = req_q.dev[7:0];
				5'd14:   cur_byte = {6'b000000, req_q.typ[9:8]};
				5'd15:   cur_byte = req_q.typ[7:0];
				5'd16:   cur_byte = req_q.obj[23:16];
				5'd17:   cur_byte = req_q.obj[15:8];
				5'd18:   cur_byte = req_q.obj[7:0];
				5'd19:   cur_byte = PROP_TAG;
				5'd20:   cur_byte = req_q.wr ? req_q.val[31:24] : ~crc16_q[7:0];
				5'd21:   cur_byte = req_q.wr ? req_q.val[23:16] : ~crc16_q[15:8];
				5'd22:   cur_byte = req_q.val[15:8];
				5'd23:   cur_byte = req_q.val[7:0];
				5'd24:   cur_byte = ~crc16_q[7:0];
				5'd25:   cur_byte = ~crc16_q[15:8];
				default: cur_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_q   <= pop_word;
			crc8_q  <= CRC8_INIT;
			crc16_q <= CRC16_INIT;
		end else if (active_q) begin
			if (pos_q >= POS_HCRC_LO && pos_q <= POS_HCRC_HI) begin
				crc8_q <= crc8_next(crc8_q, cur_byte);
			end
			if (pos_q >= POS_PAYLOAD && pos_q < dcrc_pos) begin
				crc16_q <= crc16_next(crc16_q, cur_byte);
			end
		end
		byte_q <= cur_byte;
		last_q <= cur_last;
		rej_q  <= req_q.reject;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (active_q) begin
				if (cur_last) begin
					active_q <= 1'b0;
					pos_q    <= '0;
				end else begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

	assign strobe     = strobe_q;
	assign frame_byte = byte_q;
	assign last       = last_q;
	assign rejected   = rej_q;

endmodule

// ===== rtl/core/mstp_present_value_request_framer.sv =====
// ----------------------------------------------------------------------------
// MS/TP present-value request framer
// Turns read/write present-value requests into MS/TP frames, one byte
// per cycle, with header CRC-8 and data CRC-16.
//
//   channel   handshake              word
//   request   start & !busy          opcode, dest_address, ids, value
//   result    strobe, one cycle      frame_byte, last, rejected
//   config    cfg_valid & cfg_ready  cfg_data (source address)
//
// A read frame holds 22 bytes, a write 26 and a rejected request 1, sent by
// the back-end serializer one byte per cycle.
// A queued request is loaded into the serializer; frames follow back to back.
// A two-entry queue holds pending requests; busy is high while it is full.
// Reset clears the queue and serializer and sets the source address to 1.
// The receiver cannot stall: each byte is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module mstp_present_value_request_framer
	import mpvf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [7:0]         dest_address,
	input  logic [23:0]        device_instance,
	input  logic [9:0]         object_type_code,
	input  logic [23:0]        object_instance,
	input  logic signed [31:0] value_hundredths,
	output logic               strobe,
	output logic [7:0]         frame_byte,
	output logic               last,
	output logic               rejected,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	logic push;
	req_t push_word;
	logic pop;
	req_t pop_word;
	logic nonempty;
	logic full;

	mpvf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.full             (full),
		.opcode           (opcode),
		.dest_address     (dest_address),
		.device_instance  (device_instance),
		.object_type_code (object_type_code),
		.object_instance  (object_instance),
		.value_hundredths (value_hundredths),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.cfg_ready        (cfg_ready),
		.push             (push),
		.push_word        (push_word)
	);

	mpvf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.nonempty  (nonempty),
		.full      (full)
	);

	mpvf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (nonempty),
		.pop_word   (pop_word),
		.pop        (pop),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last       (last),
		.rejected   (rejected)
	);

	assign busy = full;

	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rejected |-> last && (frame_byte == 8'h00))
		else $error("rejection word not a single zero last word");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> nonempty)
		else $error("accepted request lost");

endmodule
